// ===== hw/rtl/best_fit_core_allocator_macros.svh =====
// assertion macros for the best-fit core allocator
// used by the top level only, no other dependencies
`ifndef BEST_FIT_CORE_ALLOCATOR_MACROS_SVH
`define BEST_FIT_CORE_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BFCA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BFCA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bfca_pkg.sv =====
// shared types and constants of the best-fit core allocator
// no dependencies
package bfca_pkg;

  localparam int CORE_W        = 8;
  localparam int HOST_W        = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int NUM_HOST_REGS = 7;

  typedef logic [CORE_W-1:0] core_t;
  typedef logic [HOST_W-1:0] host_t;

  localparam core_t CORE_MAX = '1;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  typedef enum logic {
    MODE_MAX = 1'b0,
    MODE_MIN = 1'b1
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_ALLOC_MODE = 3'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef enum logic {
    UPD_DEC,
    UPD_ADD
  } upd_op_t;

  // best candidate handed from cell to cell
  typedef struct packed {
    logic  found;
    host_t idx;
    core_t grant;
    core_t slack;
  } cand_t;

  // free-count update broadcast after a transfer completes
  typedef struct packed {
    logic    valid;
    upd_op_t op;
    host_t   idx;
    core_t   amount;
  } upd_t;

  // host core register write
  typedef struct packed {
    logic  valid;
    host_t idx;
    core_t value;
  } host_load_t;

  // request seen by every cell during a scan
  typedef struct packed {
    core_t fewest_cores;
    core_t desired;
  } scan_req_t;

endpackage

// ===== hw/rtl/bfca_if.sv =====
// valid/ready channel interfaces of the best-fit core allocator
// depends on bfca_pkg
interface bfca_in_if import bfca_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  command;
  core_t fewest_cores;
  core_t most_cores;
  host_t release_host;
  core_t release_cores;

  modport source (output valid, command, fewest_cores, most_cores, release_host, release_cores,
                  input ready);
  modport sink   (input valid, command, fewest_cores, most_cores, release_host, release_cores,
                  output ready);
endinterface

interface bfca_out_if import bfca_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  granted;
  host_t chosen_host;
  core_t granted_cores;

  modport source (output valid, granted, chosen_host, granted_cores, input ready);
  modport sink   (input valid, granted, chosen_host, granted_cores, output ready);
endinterface

interface bfca_cfg_if import bfca_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  core_t                data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/best_fit_core_allocator.sv =====
// best-fit core allocator: a row of host cells scanned one host per cycle
// depends on bfca_pkg, bfca_if, bfca_cell and best_fit_core_allocator_macros.svh
//   in_chan carries one request per transfer: allocate (min/max core counts)
//   or release (host index and core count). out_chan returns one result per
//   request: granted flag, host index and core count. cfg_chan writes the
//   registers: index 0 is alloc_mode, indices 1..7 are host_cores_0..6;
//   a host write also reloads that host's free count.
//   an allocate walks the best candidate down the chain, through one register
//   per host cell, then closes the scan in the done state, where the result is
//   loaded and the update applied. a release goes straight to the done state.
//   one request is in flight at a time and the input reopens the cycle after
//   the result is loaded. the output register lets the next request enter
//   while a result waits. if the receiver stalls, the result stays in the
//   output register and the next finished request waits until that slot is free.
//   reset (synchronous, active low): alloc_mode = maximum, host 0 holds one
//   core, all other hosts absent; no result pending.
//   configuration must be written only while no request is in flight (unchecked).
`include "best_fit_core_allocator_macros.svh"

module best_fit_core_allocator import bfca_pkg::*; #(
  parameter int NUM_HOSTS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  bfca_in_if.sink      in_chan,
  bfca_out_if.source   out_chan,
  bfca_cfg_if.sink     cfg_chan
);

  localparam int PRES_W = 1 << HOST_W;

  // control state
  state_t state_r, state_nxt;
  logic   start_r;
  mode_t  mode_r;
  logic   out_valid_r;

  // captured request
  cmd_t  cmd_r;
  core_t min_r, max_r, rcores_r;
  host_t rhost_r;

  // output payload
  logic  out_granted_r;
  host_t out_host_r;
  core_t out_cores_r;

  logic in_fire, cfg_fire, out_free, done_fire;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign cfg_fire       = cfg_chan.valid && cfg_chan.ready;
  assign out_free       = !out_valid_r || out_chan.ready;
  assign done_fire      = (state_r == ST_DONE) && out_free;

  // register writes: index 0 is the mode, the rest load host cells
  host_load_t load;
  always_comb begin
    load.valid = cfg_fire && (cfg_chan.index != REG_ALLOC_MODE);
    load.idx   = host_t'(cfg_chan.index - CFG_IDX_W'(1));
    load.value = cfg_chan.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_MAX;
    end else if (cfg_fire && cfg_chan.index == REG_ALLOC_MODE) begin
      mode_r <= mode_t'(cfg_chan.data[0]);
    end
  end

  // request capture on input transfer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r    <= cmd_t'(in_chan.command);
      min_r    <= in_chan.fewest_cores;
      max_r    <= in_chan.most_cores;
      rhost_r  <= in_chan.release_host;
      rcores_r <= in_chan.release_cores;
    end
  end

  scan_req_t req;
  assign req.fewest_cores = min_r;
  assign req.desired      = (mode_r == MODE_MIN) ? min_r : max_r;

  // cell chain: the best candidate moves one cell per cycle
  logic [NUM_HOSTS:0]     cand_vld;
  cand_t                  cand [NUM_HOSTS+1];
  logic [NUM_HOSTS-1:0]   pres_vec;
  logic [PRES_W-1:0]      pres8;
  upd_t                   upd;

  assign cand_vld[0] = start_r;
  assign cand[0]     = '0;

  generate
    for (genvar i = 0; i < NUM_HOSTS; i++) begin : g_cell
      bfca_cell #(
        .CELL_IDX (i)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .upd        (upd),
        .req        (req),
        .cand_vld_i (cand_vld[i]),
        .cand_i     (cand[i]),
        .cand_vld_o (cand_vld[i+1]),
        .cand_o     (cand[i+1]),
        .present_o  (pres_vec[i])
      );
    end

    // presence seen by a release, hosts past the end read as absent
    for (genvar j = 0; j < PRES_W; j++) begin : g_pres
      if (j < NUM_HOSTS) begin : g_in
        assign pres8[j] = pres_vec[j];
      end else begin : g_out
        assign pres8[j] = 1'b0;
      end
    end
  endgenerate

  cand_t last;
  logic  last_vld;
  assign last     = cand[NUM_HOSTS];
  assign last_vld = cand_vld[NUM_HOSTS];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_chan.command == CMD_RELEASE) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_vld) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= in_fire && (in_chan.command == CMD_ALLOC);
    end
  end

  // result and state update
  logic  res_granted, rel_ok;
  host_t res_host;
  core_t res_cores;

  always_comb begin
    rel_ok      = pres8[rhost_r];
    res_granted = 1'b0;
    res_host    = '0;
    res_cores   = '0;
    upd         = '0;
    case (cmd_r)
      CMD_RELEASE: begin
        res_granted = rel_ok;
        res_host    = rhost_r;
        res_cores   = rel_ok ? rcores_r : '0;
        upd.valid   = done_fire && rel_ok;
        upd.op      = UPD_ADD;
        upd.idx     = rhost_r;
        upd.amount  = rcores_r;
      end
      default: begin
        res_granted = last.found;
        res_host    = last.found ? last.idx : '0;
        res_cores   = last.found ? last.grant : '0;
        upd.valid   = done_fire && last.found;
        upd.op      = UPD_DEC;
        upd.idx     = last.idx;
        upd.amount  = last.grant;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_granted_r <= res_granted;
      out_host_r    <= res_host;
      out_cores_r   <= res_cores;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.granted       = out_granted_r;
  assign out_chan.chosen_host   = out_host_r;
  assign out_chan.granted_cores = out_cores_r;

  // checks
  `BFCA_ASSERT_IMPL(a_chain_single, clk, rst_n, 1'b1, $onehot0(cand_vld), "more than one candidate in the chain")
  `BFCA_ASSERT_IMPL(a_scan_end, clk, rst_n, last_vld, state_r == ST_SCAN, "scan result outside scan")
  `BFCA_ASSERT_NEXT(a_update_out, clk, rst_n, upd.valid, out_valid_r && state_r == ST_IDLE, "update without result")

endmodule

// ===== hw/rtl/bfca_cell.sv =====
// one host cell: free-core count, presence flag and one compare step of the scan
// depends on bfca_pkg
module bfca_cell import bfca_pkg::*; #(
  parameter int CELL_IDX = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  host_load_t load,
  input  upd_t       upd,
  input  scan_req_t  req,
  input  logic       cand_vld_i,
  input  cand_t      cand_i,
  output logic       cand_vld_o,
  output cand_t      cand_o,
  output logic       present_o
);

  localparam bit    HAS_REG = (CELL_IDX < NUM_HOST_REGS);
  localparam host_t MY_IDX  = host_t'(CELL_IDX);

  core_t own_free;
  logic  own_present;

  generate
    if (HAS_REG) begin : g_host
      localparam core_t RST_CORES = (CELL_IDX == 0) ? core_t'(1) : core_t'(0);
      localparam logic  RST_PRES  = (CELL_IDX == 0);

      core_t             free_r, free_nxt;
      logic              present_r, present_nxt;
      logic [CORE_W:0]   sum;

      assign sum = {1'b0, free_r} + {1'b0, upd.amount};

      always_comb begin
        free_nxt    = free_r;
        present_nxt = present_r;
        if (load.valid && load.idx == MY_IDX) begin
          free_nxt    = load.value;
          present_nxt = (load.value != '0);
        end else if (upd.valid && upd.idx == MY_IDX && present_r) begin
          case (upd.op)
            UPD_DEC: free_nxt = free_r - upd.amount;
            UPD_ADD: free_nxt = sum[CORE_W] ? CORE_MAX : sum[CORE_W-1:0];
            default: free_nxt = free_r;
          endcase
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          free_r    <= RST_CORES;
          present_r <= RST_PRES;
        end else begin
          free_r    <= free_nxt;
          present_r <= present_nxt;
        end
      end

      assign own_free    = free_r;
      assign own_present = present_r;
    end else begin : g_absent
      assign own_free    = '0;
      assign own_present = 1'b0;
    end
  endgenerate

  // compare this host against the best so far
  core_t grant, slack;
  logic  qual, take;
  cand_t cand_r, cand_nxt;
  logic  cand_vld_r;

  always_comb begin
    qual  = own_present && (own_free >= req.fewest_cores);
    grant = (own_free < req.desired) ? own_free : req.desired;
    slack = own_free - grant;
    take  = qual && (!cand_i.found || grant > cand_i.grant ||
                     (grant == cand_i.grant && slack < cand_i.slack));
    cand_nxt = cand_i;
    if (take) begin
      cand_nxt.found = 1'b1;
      cand_nxt.idx   = MY_IDX;
      cand_nxt.grant = grant;
      cand_nxt.slack = slack;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_vld_r <= 1'b0;
    end else begin
      cand_vld_r <= cand_vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (cand_vld_i) begin
      cand_r <= cand_nxt;
    end
  end

  assign cand_vld_o = cand_vld_r;
  assign cand_o     = cand_r;
  assign present_o  = own_present;

endmodule

// ===== dv/tb_best_fit_core_allocator.sv =====
// self-checking testbench for best_fit_core_allocator: directed table plus random phases
// depends on bfca_pkg, bfca_if and the allocator rtl; results are checked against an
// in-bench model of the per-host free-core counts
`timescale 1ns / 100ps

module tb_best_fit_core_allocator;
  import bfca_pkg::*;

  localparam int NUM_HOSTS        = 8;
  localparam int CLK_HALF         = 4;
  localparam int RESET_CYCLES     = 4;
  localparam int NUM_PHASES       = 7;
  localparam int ITEMS_PER_PHASE  = 200;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int DRAIN_LIMIT      = 5000;
  localparam int TAIL_CYCLES      = 20;
  localparam int MAX_PRINTED      = 40;
  localparam longint TIMEOUT_NS   = 4_000_000;

  // register map: alloc_mode at REG_ALLOC_MODE, host_cores_h at REG_HOST_0 + h
  localparam logic [CFG_IDX_W-1:0] REG_HOST_0 = 3'd1;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN
  } rx_style_t;

  typedef struct packed {
    cmd_t  cmd;
    core_t min_c;
    core_t max_c;
    host_t rhost;
    core_t rcores;
  } req_t;

  typedef struct packed {
    logic  granted;
    host_t host;
    core_t cores;
  } grant_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] idx;
    core_t                val;
  } reg_wr_t;

  // one line of the directed table: either a register write or a request,
  // a request optionally carrying a hand-written expected result
  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    core_t                reg_val;
    req_t                 req;
    bit                   typed;
    grant_t               want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;

  bfca_in_if  in_chan ();
  bfca_out_if out_chan ();
  bfca_cfg_if cfg_chan ();

  best_fit_core_allocator #(
    .NUM_HOSTS (NUM_HOSTS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // allocator model state
  mode_t   alloc_mode_q;
  core_t   host_size [NUM_HOST_REGS];
  core_t   free_cnt  [NUM_HOSTS];

  grant_t  pending_grants [$];
  reg_wr_t cfg_pending [$];
  row_t    dir_rows [$];

  int mismatch_count = 0;
  bit long_hold_req  = 1'b0;

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  // append helpers for the stimulus queues
  function automatic void add_row(row_t rw);
    dir_rows.insert(dir_rows.size(), rw);
  endfunction

  function automatic void queue_write(logic [CFG_IDX_W-1:0] idx, core_t val);
    cfg_pending.insert(cfg_pending.size(), {idx, val});
  endfunction

  function automatic bit host_present(int h);
    return h < NUM_HOST_REGS && host_size[h] != '0;
  endfunction

  // best-fit decision plus the free-count update it implies
  function automatic grant_t serve_request(req_t r);
    grant_t res;
    int     desired, f, g, s, best, best_g, best_s;
    bit     hit;
    res = '0;
    if (r.cmd == CMD_RELEASE) begin
      // release always echoes the host; absent hosts (incl. the one without
      // a register) leave the counts alone
      res.host = r.rhost;
      if (host_present(int'(r.rhost))) begin
        f = int'(free_cnt[r.rhost]) + int'(r.rcores);
        free_cnt[r.rhost] = (f > int'(CORE_MAX)) ? CORE_MAX : core_t'(f);
        res.granted = 1'b1;
        res.cores   = r.rcores;
      end
      return res;
    end
    desired = (alloc_mode_q == MODE_MIN) ? int'(r.min_c) : int'(r.max_c);
    hit     = 1'b0;
    best    = 0;
    best_g  = 0;
    best_s  = 0;
    for (int i = 0; i < NUM_HOSTS; i++) begin
      if (host_present(i)) begin
        f = int'(free_cnt[i]);
        if (f >= int'(r.min_c)) begin
          // grant may fall below the minimum when min > max in maximum mode
          g = (f < desired) ? f : desired;
          s = f - g;
          if (!hit || g > best_g || (g == best_g && s < best_s)) begin
            hit    = 1'b1;
            best   = i;
            best_g = g;
            best_s = s;
          end
        end
      end
    end
    if (hit) begin
      free_cnt[best] = free_cnt[best] - core_t'(best_g);
      res.granted    = 1'b1;
      res.host       = host_t'(best);
      res.cores      = core_t'(best_g);
    end
    return res;
  endfunction

  // a host write also reloads that host's free count
  function automatic void load_register(logic [CFG_IDX_W-1:0] idx, core_t val);
    int h;
    if (idx == REG_ALLOC_MODE) begin
      alloc_mode_q = mode_t'(val[0]);
    end else begin
      h = int'(idx) - int'(REG_HOST_0);
      host_size[h] = val;
      free_cnt[h]  = val;
    end
  endfunction

  function automatic row_t req_row(cmd_t c, int mn, int mx, int rh, int rc);
    row_t rw;
    rw.is_cfg     = 1'b0;
    rw.reg_idx    = '0;
    rw.reg_val    = '0;
    rw.req.cmd    = c;
    rw.req.min_c  = core_t'(mn);
    rw.req.max_c  = core_t'(mx);
    rw.req.rhost  = host_t'(rh);
    rw.req.rcores = core_t'(rc);
    rw.typed      = 1'b0;
    rw.want       = '0;
    return rw;
  endfunction

  function automatic row_t fixed_row(cmd_t c, int mn, int mx, int rh, int rc, grant_t w);
    row_t rw;
    rw       = req_row(c, mn, mx, rh, rc);
    rw.typed = 1'b1;
    rw.want  = w;
    return rw;
  endfunction

  function automatic row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int val);
    row_t rw;
    rw         = req_row(CMD_ALLOC, 0, 0, 0, 0);
    rw.is_cfg  = 1'b1;
    rw.reg_idx = idx;
    rw.reg_val = core_t'(val);
    return rw;
  endfunction

  // core counts biased toward small values, with the extremes mixed in
  function automatic core_t pick_count();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CORE_MAX;
      2, 3:    return core_t'($urandom_range(0, 255));
      default: return core_t'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic req_t random_request();
    req_t  r;
    core_t t;
    r.cmd    = ($urandom_range(0, 99) < 55) ? CMD_ALLOC : CMD_RELEASE;
    r.min_c  = pick_count();
    r.max_c  = pick_count();
    r.rhost  = host_t'($urandom_range(0, 7));
    r.rcores = pick_count();
    // mostly well-ordered min/max, the rest left inverted
    if ($urandom_range(0, 3) != 0 && r.min_c > r.max_c) begin
      t       = r.min_c;
      r.min_c = r.max_c;
      r.max_c = t;
    end
    return r;
  endfunction

  // offer one request and hold it until the transfer, then predict
  task automatic send_request(req_t r, bit typed, grant_t want);
    grant_t model_res;
    in_chan.valid         <= 1'b1;
    in_chan.command       <= r.cmd;
    in_chan.fewest_cores  <= r.min_c;
    in_chan.most_cores    <= r.max_c;
    in_chan.release_host  <= r.rhost;
    in_chan.release_cores <= r.rcores;
    do @(posedge clk); while (!in_chan.ready);
    model_res = serve_request(r);
    pending_grants.insert(pending_grants.size(), typed ? want : model_res);
  endtask

  // wait until every result is back, then write the queued registers back to back
  task automatic apply_settings();
    reg_wr_t w;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    while (cfg_pending.size() != 0) begin
      w = cfg_pending.pop_front();
      cfg_chan.valid <= 1'b1;
      cfg_chan.index <= w.idx;
      cfg_chan.data  <= w.val;
      do @(posedge clk); while (!cfg_chan.ready);
      load_register(w.idx, w.val);
    end
    cfg_chan.valid <= 1'b0;
  endtask

  // result checker: every transfer on the result side pops the oldest expectation
  always @(posedge clk) begin
    grant_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_grants.size() == 0) begin
        report_mismatch("result transfer with no request outstanding");
      end else begin
        want = pending_grants.pop_front();
        if (out_chan.granted !== want.granted) begin
          report_mismatch($sformatf("granted %0b, expected %0b",
                                    out_chan.granted, want.granted));
        end
        if (out_chan.chosen_host !== want.host) begin
          report_mismatch($sformatf("chosen_host %0d, expected %0d",
                                    out_chan.chosen_host, want.host));
        end
        if (out_chan.granted_cores !== want.cores) begin
          report_mismatch($sformatf("granted_cores %0d, expected %0d",
                                    out_chan.granted_cores, want.cores));
        end
      end
    end
  end

  // result-side backpressure: segments of always-ready, random and rotating-mask
  // stalls; a long hold on request lets the block fill up and stall its input
  initial begin
    int        hold_left;
    int        seg_left;
    rx_style_t style;
    logic [7:0] mask;
    out_chan.ready = 1'b0;
    hold_left      = 0;
    seg_left       = 0;
    style          = RX_ALWAYS;
    mask           = 8'hff;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD_CYCLES;
      end
      if (seg_left == 0) begin
        style    = rx_style_t'($urandom_range(0, 2));
        seg_left = $urandom_range(20, 300);
        mask     = 8'($urandom);
        if (mask == 8'h00) begin
          mask = 8'h01;
        end
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        case (style)
          RX_ALWAYS: begin
            out_chan.ready <= 1'b1;
          end
          RX_RANDOM: begin
            out_chan.ready <= ($urandom_range(0, 99) < 60);
          end
          default: begin
            out_chan.ready <= mask[0];
            mask = {mask[0], mask[7:1]};
          end
        endcase
      end
    end
  end

  // main stimulus
  initial begin
    int burst, gap, sent, drain;
    in_chan.valid         = 1'b0;
    in_chan.command       = 1'b0;
    in_chan.fewest_cores  = '0;
    in_chan.most_cores    = '0;
    in_chan.release_host  = '0;
    in_chan.release_cores = '0;
    cfg_chan.valid        = 1'b0;
    cfg_chan.index        = '0;
    cfg_chan.data         = '0;
    rst_n                 = 1'b0;

    // model after reset: maximum mode, host 0 has one core, the rest absent
    alloc_mode_q = MODE_MAX;
    for (int h = 0; h < NUM_HOST_REGS; h++) begin
      host_size[h] = '0;
    end
    host_size[0] = 8'd1;
    for (int h = 0; h < NUM_HOSTS; h++) begin
      free_cnt[h] = (h < NUM_HOST_REGS) ? host_size[h] : '0;
    end

    // reset-state rows: results are obvious from the reset values
    add_row(fixed_row(CMD_ALLOC,   1,   1, 0,   0, {1'b1, 3'd0, 8'd1}));
    // host 0 now empty: nothing qualifies
    add_row(fixed_row(CMD_ALLOC,   1, 255, 0,   0, {1'b0, 3'd0, 8'd0}));
    // zero minimum lets an empty present host win with a zero grant
    add_row(fixed_row(CMD_ALLOC,   0, 255, 0,   0, {1'b1, 3'd0, 8'd0}));
    // host 7 has no register, host 3 is absent after reset
    add_row(fixed_row(CMD_RELEASE, 0,   0, 7,   5, {1'b0, 3'd7, 8'd0}));
    add_row(fixed_row(CMD_RELEASE, 0,   0, 3,   9, {1'b0, 3'd3, 8'd0}));
    // refill host 0 to the top, then overflow saturates
    add_row(fixed_row(CMD_RELEASE, 0,   0, 0, 255, {1'b1, 3'd0, 8'd255}));
    add_row(fixed_row(CMD_RELEASE, 0,   0, 0,   1, {1'b1, 3'd0, 8'd1}));
    add_row(fixed_row(CMD_ALLOC, 255, 255, 0,   0, {1'b1, 3'd0, 8'd255}));

    // mixed host sizes with tied grants, an absent host and both extremes
    add_row(cfg_row(REG_ALLOC_MODE, MODE_MAX));
    add_row(cfg_row(REG_HOST_0 + 3'd0,  10));
    add_row(cfg_row(REG_HOST_0 + 3'd1,  20));
    add_row(cfg_row(REG_HOST_0 + 3'd2,  20));
    add_row(cfg_row(REG_HOST_0 + 3'd3,   5));
    add_row(cfg_row(REG_HOST_0 + 3'd4, 255));
    add_row(cfg_row(REG_HOST_0 + 3'd5,   0));
    add_row(cfg_row(REG_HOST_0 + 3'd6,   1));
    // tie on grant goes to the smaller slack, then the lower index
    add_row(req_row(CMD_ALLOC,     5,  20, 0,   0));
    add_row(req_row(CMD_ALLOC,     5,  20, 0,   0));
    // minimum above maximum in maximum mode
    add_row(req_row(CMD_ALLOC,   200, 100, 0,   0));
    add_row(req_row(CMD_RELEASE,   0,   0, 5,   3));
    add_row(req_row(CMD_RELEASE,   0,   0, 6, 255));
    add_row(req_row(CMD_ALLOC,     0,   0, 0,   0));
    add_row(req_row(CMD_ALLOC,   255,   1, 0,   0));
    add_row(cfg_row(REG_ALLOC_MODE, MODE_MIN));
    add_row(req_row(CMD_ALLOC,     3, 200, 0,   0));
    add_row(req_row(CMD_ALLOC,     1, 255, 0,   0));
    add_row(req_row(CMD_ALLOC,   255, 255, 0,   0));
    add_row(req_row(CMD_RELEASE,   0,   0, 7,   0));
    add_row(req_row(CMD_RELEASE,   0,   0, 2,   0));
    add_row(req_row(CMD_ALLOC,     0,   0, 0,   0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: register rows queue up and are written before the next request
    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) begin
        queue_write(dir_rows[k].reg_idx, dir_rows[k].reg_val);
      end else begin
        if (cfg_pending.size() != 0) begin
          in_chan.valid <= 1'b0;
          apply_settings();
        end
        send_request(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);
      end
    end
    in_chan.valid <= 1'b0;

    // random phases, each with its own register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      queue_write(REG_ALLOC_MODE,
                  core_t'((p == 1) ? MODE_MIN :
                          (p == 0) ? MODE_MAX : $urandom_range(0, 1)));
      for (int h = 0; h < NUM_HOST_REGS; h++) begin
        if (p == 0) begin
          // every host full-size
          queue_write(REG_HOST_0 + 3'(h), CORE_MAX);
        end else if (p == 1) begin
          // every host a single core
          queue_write(REG_HOST_0 + 3'(h), core_t'(1));
        end else begin
          case ($urandom_range(0, 9))
            0:       queue_write(REG_HOST_0 + 3'(h), core_t'(0));
            1:       queue_write(REG_HOST_0 + 3'(h), CORE_MAX);
            2:       queue_write(REG_HOST_0 + 3'(h), core_t'($urandom_range(0, 255)));
            default: queue_write(REG_HOST_0 + 3'(h), core_t'($urandom_range(1, 30)));
          endcase
        end
      end
      apply_settings();

      // long receiver hold while requests keep coming
      if (p == 2 || p == 5) begin
        long_hold_req = 1'b1;
      end

      // bursts of back-to-back requests separated by random gaps
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        burst = $urandom_range(1, 40);
        for (int b = 0; b < burst && sent < ITEMS_PER_PHASE; b++) begin
          send_request(random_request(), 1'b0, '0);
          sent++;
        end
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          in_chan.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      in_chan.valid <= 1'b0;
    end

    // drain outstanding results, then a short quiet tail for stray transfers
    drain = 0;
    while (pending_grants.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    if (pending_grants.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                pending_grants.size()));
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/bfca_pkg.sv
hw/rtl/bfca_if.sv
hw/rtl/bfca_cell.sv
hw/rtl/best_fit_core_allocator.sv
dv/tb_best_fit_core_allocator.sv
